### rtl/binary_image_rotate_45_macros.svh
// assertion macros for the binary_image_rotate_45 rtl
// expects clk and rst_n in the scope of each use
`ifndef BINARY_IMAGE_ROTATE_45_MACROS_SVH
`define BINARY_IMAGE_ROTATE_45_MACROS_SVH

// same-cycle implication, checked out of reset
`define BIR45_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BIR45_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bir45_pkg.sv
// shared types, constants and coordinate mapping for the 45 degree rotator
// no dependencies
`timescale 1ns / 1ps

package bir45_pkg;

    localparam int IMAGE_SIZE = 64;
    localparam int COORD_W    = $clog2(IMAGE_SIZE);
    localparam int NUM_W      = 26;
    localparam int QUOT_LSB   = 17;

    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(IMAGE_SIZE - 1);

    // 2 * 46341, the q16 form of 1/sqrt2 doubled, and n * 65536 for centering
    localparam logic signed [NUM_W-1:0] MAP_GAIN = NUM_W'(2 * 46341);
    localparam logic signed [NUM_W-1:0] MAP_BIAS = NUM_W'(IMAGE_SIZE * 65536);

    typedef struct packed {
        logic [IMAGE_SIZE-1:0] row_bits;
        logic [COORD_W-1:0]    row_index;
        logic                  finish;
    } in_word_t;

    typedef struct packed {
        logic [IMAGE_SIZE-1:0] out_row_bits;
        logic [COORD_W-1:0]    out_row_index;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] q;
    } coord_t;

    typedef struct packed {
        logic [IMAGE_SIZE-1:0]              hit;
        logic [IMAGE_SIZE-1:0][COORD_W-1:0] xo;
        logic [IMAGE_SIZE-1:0][COORD_W-1:0] yo;
    } map_t;

    typedef struct packed {
        logic scatter;
        logic shift;
    } store_ctrl_t;

    // rounded centered coordinate for offset t, ok low when off-image
    function automatic coord_t map_coord(input logic signed [7:0] t);
        logic signed [NUM_W-1:0] num;
        coord_t                  c;
        num  = NUM_W'(t) * MAP_GAIN + MAP_BIAS;
        c.ok = (num[NUM_W-1:QUOT_LSB+COORD_W] == '0);
        c.q  = num[QUOT_LSB+COORD_W-1:QUOT_LSB];
        return c;
    endfunction

endpackage

### rtl/binary_image_rotate_45.sv
// top level of the 45 degree one-bit image rotator: control sequencer
// depends on bir45_pkg, bir45_map, bir45_store and the assertion macros
`timescale 1ns / 1ps
`include "binary_image_rotate_45_macros.svh"

// channel   ports                   word         handshake
// input     start, busy, item       in_word_t    taken when start && !busy
// result    result_valid, result    out_word_t   one word per cycle, no stall
//
// a source row is mapped across its 64 columns into a register when it
// is taken, then its hits are merged into the 64 store rows in the
// scatter state. a finish row then emits 64 words, one per cycle, from
// the head of the store as it shifts down. busy stays high until the last word.
// reset clears the store and the sequencer.

module binary_image_rotate_45
    import bir45_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  item,
    output logic      result_valid,
    output out_word_t result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [COORD_W-1:0]    cnt_reg;
    logic [COORD_W-1:0]    cnt_next;
    logic                  finish_reg;
    logic                  finish_next;
    logic                  accept;
    map_t                  mapped;
    store_ctrl_t           ctrl;
    logic [IMAGE_SIZE-1:0] head_row;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    bir45_map u_map (
        .clk    (clk),
        .load   (accept),
        .item   (item),
        .mapped (mapped)
    );

    assign ctrl.scatter = (state_reg == ST_SCAT);
    assign ctrl.shift   = (state_reg == ST_EMIT);

    bir45_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .mapped   (mapped),
        .head_row (head_row)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        finish_next = finish_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    finish_next = item.finish;
                    state_next  = ST_SCAT;
                end
            end
            ST_SCAT:
            begin
                cnt_next = '0;
                if (finish_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            finish_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            finish_reg <= finish_next;
        end
    end

    assign result_valid         = (state_reg == ST_EMIT);
    assign result.out_row_bits  = head_row;
    assign result.out_row_index = cnt_reg;
    assign result.last          = (cnt_reg == LAST_ROW);

    `BIR45_ASSERT_NEXT(a_accept_scatters, accept, state_reg == ST_SCAT,
        "accepted word did not move to scatter")
    `BIR45_ASSERT_NEXT(a_plain_row_returns, (state_reg == ST_SCAT) && !finish_reg,
        state_reg == ST_IDLE, "row without finish did not return to idle")
    `BIR45_ASSERT_NEXT(a_emit_counts_up, result_valid && !result.last,
        result_valid && (cnt_reg == $past(cnt_reg) + 1'b1), "emit count skipped")
    `BIR45_ASSERT_NEXT(a_last_ends_emit, result_valid && result.last,
        !result_valid && !busy, "emission did not end after last word")
    `BIR45_ASSERT_NOW(a_strobe_busy, result_valid, busy,
        "result strobe while not busy")

endmodule

### rtl/bir45_map.sv
// column lanes: map every source pixel of one row to its destination pixel
// depends on bir45_pkg
`timescale 1ns / 1ps

module bir45_map
    import bir45_pkg::*;
(
    input  logic     clk,
    input  logic     load,
    input  in_word_t item,
    output map_t     mapped
);

    map_t mapped_reg;
    map_t mapped_next;

    for (genvar x = 0; x < IMAGE_SIZE; x++) begin : g_col
        logic signed [7:0] d_off;
        logic signed [7:0] s_off;
        coord_t            cx;
        coord_t            cy;

        always_comb
        begin
            d_off = 8'(x) - $signed({2'b00, item.row_index});
            s_off = 8'(x) + $signed({2'b00, item.row_index}) - 8'(IMAGE_SIZE - 1);
            cx    = map_coord(d_off);
            cy    = map_coord(s_off);
            mapped_next.hit[x] = item.row_bits[x] && cx.ok && cy.ok;
            mapped_next.xo[x]  = cx.q;
            mapped_next.yo[x]  = cy.q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped = mapped_reg;

endmodule

### rtl/bir45_store.sv
// row lanes: destination store, each row merges the hits aimed at it
// shifts down by one row per emitted word; depends on bir45_pkg
`timescale 1ns / 1ps

module bir45_store
    import bir45_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_ctrl_t           ctrl,
    input  map_t                  mapped,
    output logic [IMAGE_SIZE-1:0] head_row
);

    logic [IMAGE_SIZE-1:0] rows_reg  [IMAGE_SIZE];
    logic [IMAGE_SIZE-1:0] rows_next [IMAGE_SIZE];

    for (genvar r = 0; r < IMAGE_SIZE; r++) begin : g_row
        logic [IMAGE_SIZE-1:0] hits;

        always_comb
        begin
            hits = '0;
            for (int x = 0; x < IMAGE_SIZE; x++)
            begin
                if (mapped.hit[x] && (mapped.yo[x] == COORD_W'(r)))
                begin
                    hits[mapped.xo[x]] = 1'b1;
                end
            end
        end

        always_comb
        begin
            if (ctrl.shift)
            begin
                if (r == IMAGE_SIZE - 1)
                begin
                    rows_next[r] = '0;
                end
                else
                begin
                    rows_next[r] = rows_reg[(r + 1) % IMAGE_SIZE];
                end
            end
            else if (ctrl.scatter)
            begin
                rows_next[r] = rows_reg[r] | hits;
            end
            else
            begin
                rows_next[r] = rows_reg[r];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rows_reg[r] <= '0;
            end
            else
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

    assign head_row = rows_reg[0];

endmodule

### bench/tb.sv
// self-checking bench for binary_image_rotate_45: a directed table of rows, then random images
// expected rotated rows come from a forward-mapping predictor kept in this file; needs bir45_pkg
`timescale 1ns / 1ps

module tb
    import bir45_pkg::*;
();

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     WORD_GOAL   = 360;
    localparam int     PLAN_LEN    = 19;
    localparam int     TAIL_CYCLES = 20;
    localparam longint COS_Q16     = 46341;
    localparam longint HALF_SCALE  = 65536;
    localparam longint FULL_SCALE  = 131072;
    localparam logic [IMAGE_SIZE-1:0] ONES = '1;

    typedef struct packed {
        logic [IMAGE_SIZE-1:0] bits;
        logic [COORD_W-1:0]    row;
        logic                  fin;
        logic                  blank;
    } plan_row_t;

    // blank set: the finish emits 64 all-zero rows
    localparam plan_row_t DIRECTED [PLAN_LEN] = '{
        {64'h0000_0000_0000_0000, 6'd0,  1'b1, 1'b1},
        {64'h0000_0000_0000_0001, 6'd0,  1'b1, 1'b1},
        {64'h8000_0000_0000_0000, 6'd63, 1'b1, 1'b1},
        {64'h8000_0000_0000_0000, 6'd0,  1'b0, 1'b0},
        {64'h0000_0000_0000_0001, 6'd63, 1'b1, 1'b1},
        {64'h0000_0000_8000_0000, 6'd31, 1'b1, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd0,  1'b0, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd63, 1'b0, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd31, 1'b0, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd32, 1'b1, 1'b0},
        {64'haaaa_aaaa_aaaa_aaaa, 6'd1,  1'b0, 1'b0},
        {64'h5555_5555_5555_5555, 6'd62, 1'b0, 1'b0},
        {64'haaaa_aaaa_aaaa_aaaa, 6'd62, 1'b0, 1'b0},
        {64'h8000_0000_0000_0001, 6'd42, 1'b1, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd21, 1'b0, 1'b0},
        {64'h0123_4567_89ab_cdef, 6'd10, 1'b1, 1'b0},
        {64'hfedc_ba98_7654_3210, 6'd53, 1'b0, 1'b0},
        {64'hffff_ffff_ffff_ffff, 6'd31, 1'b1, 1'b0},
        {64'h0000_0000_0000_0000, 6'd63, 1'b1, 1'b1}
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  item;
    logic      result_valid;
    out_word_t result;

    logic [IMAGE_SIZE-1:0] rot_img [IMAGE_SIZE];
    out_word_t             pending_rows [$];
    int                    mismatches = 0;
    int                    cycles     = 0;
    int                    words_sent = 0;

    binary_image_rotate_45 u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // rounded centered destination coordinate, -1 when off-image
    function automatic int map_axis(input int t);
        longint num;
        longint q;
        num = 2 * longint'(t) * COS_Q16 + longint'(IMAGE_SIZE) * HALF_SCALE;
        if (num < 0)
            return -1;
        q = num / FULL_SCALE;
        if (q >= IMAGE_SIZE)
            return -1;
        return int'(q);
    endfunction

    task automatic rotate_accept(input in_word_t w, input logic blank);
        int        xo;
        int        yo;
        out_word_t r;
        for (int x = 0; x < IMAGE_SIZE; x++)
        begin
            if (w.row_bits[x])
            begin
                xo = map_axis(x - int'(w.row_index));
                yo = map_axis(x + int'(w.row_index) - (IMAGE_SIZE - 1));
                if (xo >= 0 && yo >= 0)
                    rot_img[yo][xo] = 1'b1;
            end
        end
        if (w.finish)
        begin
            for (int y = 0; y < IMAGE_SIZE; y++)
            begin
                r.out_row_bits  = blank ? '0 : rot_img[y];
                r.out_row_index = COORD_W'(y);
                r.last          = (y == IMAGE_SIZE - 1);
                pending_rows.push_back(r);
                rot_img[y] = '0;
            end
        end
    endtask

    task automatic send_word(input in_word_t w, input logic blank);
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        rotate_accept(w, blank);
        words_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= in_word_t'({$urandom, $urandom, 6'($urandom), 1'($urandom)});
        end
    endtask

    // calm stretch with no gaps in the middle of the random part
    task automatic maybe_idle;
        if (words_sent >= 200 && words_sent < 270)
            return;
        if ($urandom_range(99) < 29)
            idle_cycles($urandom_range(9) == 0 ? $urandom_range(20, 90)
                                               : $urandom_range(1, 5));
    endtask

    task automatic drain_results;
        @(negedge clk);
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IMAGE_SIZE-1:0] pick_bits();
        logic [IMAGE_SIZE-1:0] a;
        logic [IMAGE_SIZE-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(6))
            0: return a & b & {$urandom, $urandom};
            1: return a | b;
            2: return ONES << $urandom_range(IMAGE_SIZE - 1);
            3: return 64'h1 << $urandom_range(IMAGE_SIZE - 1);
            4: return ONES;
            default: return a;
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: row %0d bits %h last %b",
                             result.out_row_index, result.out_row_bits, result.last);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (result.out_row_bits !== want.out_row_bits ||
                    result.out_row_index !== want.out_row_index ||
                    result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected row %0d bits %h last %b,",
                                  " got row %0d bits %h last %b"},
                                 want.out_row_index, want.out_row_bits, want.last,
                                 result.out_row_index, result.out_row_bits, result.last);
                end
            end
        end
    end

    initial
    begin
        int       n;
        int       base;
        int       images;
        logic     ordered;
        in_word_t w;
        images = 0;
        start  = 1'b0;
        item   = '0;
        rst_n  = 1'b0;
        for (int y = 0; y < IMAGE_SIZE; y++)
            rot_img[y] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            send_word({DIRECTED[i].bits, DIRECTED[i].row, DIRECTED[i].fin}, DIRECTED[i].blank);
            maybe_idle();
        end
        drain_results();

        while (words_sent < WORD_GOAL)
        begin
            if (images == 0 || $urandom_range(11) == 0)
            begin
                // full scan, rows in order
                for (int y = 0; y < IMAGE_SIZE; y++)
                begin
                    w.row_bits  = pick_bits();
                    w.row_index = COORD_W'(y);
                    w.finish    = (y == IMAGE_SIZE - 1);
                    send_word(w, 1'b0);
                    maybe_idle();
                end
            end
            else
            begin
                n       = $urandom_range(1, 14);
                base    = $urandom_range(IMAGE_SIZE - 1);
                ordered = $urandom_range(1);
                for (int k = 0; k < n; k++)
                begin
                    w.row_bits  = pick_bits();
                    w.row_index = ordered ? COORD_W'(base + k) : COORD_W'($urandom_range(63));
                    w.finish    = (k == n - 1) || ($urandom_range(19) == 0);
                    send_word(w, 1'b0);
                    maybe_idle();
                end
            end
            images++;
            if (images == 6)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
